>>> rtl/stws_pkg.sv
`default_nettype none

package stws_pkg;

	localparam int CAPACITY   = 64;
	localparam int SLOT_W     = 6;
	localparam int CNT_W      = 7;
	localparam int ELEM_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_FIND = 2'd1,
		OP_DEL  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]            func;
		logic [SLOT_W-1:0]     index;
		logic [CNT_W-1:0]      window_len;
		logic [ELEM_WIDTH-1:0] elem;
		logic                  first;
		logic                  last;
	} req_t;

	typedef struct packed {
		logic              placed;
		logic [CNT_W-1:0]  placed_total;
		logic              found;
		logic [SLOT_W-1:0] position;
		logic [CNT_W-1:0]  occupied_count;
		logic              run_done;
	} resp_t;

	typedef struct packed {
		logic load;
		logic put_step;
		logic find_step;
		logic other_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic put_fin;
		logic find_fin;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/stws_ctrl.sv
`default_nettype none

module stws_ctrl import stws_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] func,
	input  wire dp_sts_t    sts,
	output ctl_cmd_t        cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PUT   = 5'b00010,
		S_FIND  = 5'b00100,
		S_OTHER = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (func)
						OP_PUT:  state_nx = S_PUT;
						OP_FIND: state_nx = S_FIND;
						default: state_nx = S_OTHER;
					endcase
				end
			end
			S_PUT: begin
				if (sts.put_fin) state_nx = S_RESP;
			end
			S_FIND: begin
				if (sts.find_fin) state_nx = S_RESP;
			end
			S_OTHER: state_nx = S_RESP;
			S_RESP:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd.load       = (state_q == S_IDLE) && start;
		cmd.put_step   = (state_q == S_PUT);
		cmd.find_step  = (state_q == S_FIND);
		cmd.other_step = (state_q == S_OTHER);
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

>>> rtl/stws_dp.sv
`default_nettype none

module stws_dp import stws_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t cmd,
	input  wire req_t     req,
	output dp_sts_t       sts,
	output resp_t         rsp
);

	logic [ELEM_WIDTH-1:0] mem [CAPACITY];

	req_t                  req_q;
	resp_t                 rsp_q, rsp_nx;
	logic [CAPACITY-1:0]   valid_q;
	logic [CNT_W-1:0]      vtot_q, vtot_nx;
	logic [CNT_W-1:0]      cur_q, wend_q, rplaced_q, rplaced_nx;
	logic [CNT_W-1:0]      scan_q;
	logic                  rd_vld_s1;
	logic [SLOT_W-1:0]     rd_addr_s1;
	logic [ELEM_WIDTH-1:0] rd_data_s1;

	logic [CNT_W:0]   end_sum;
	logic [CNT_W-1:0] wend_init;
	logic             put_in_win, put_wr, put_fin;
	logic             find_hit, find_fin;
	logic             del_clr, res_ld;

	assign end_sum   = {2'b00, req.index} + {1'b0, req.window_len};
	assign wend_init = (end_sum > (CNT_W+1)'(CAPACITY)) ? CNT_W'(CAPACITY) : end_sum[CNT_W-1:0];

	assign put_in_win = (cur_q < wend_q);
	assign put_wr     = cmd.put_step && put_in_win && !valid_q[cur_q[SLOT_W-1:0]];
	assign put_fin    = put_wr || !put_in_win;

	assign find_hit = rd_vld_s1 && valid_q[rd_addr_s1] && (rd_data_s1 == req_q.elem);
	assign find_fin = find_hit || (!rd_vld_s1 && (scan_q == CNT_W'(CAPACITY)));

	assign del_clr = cmd.other_step && (req_q.func == OP_DEL) && valid_q[req_q.index];

	assign rplaced_nx = put_wr ? rplaced_q + CNT_W'(1) : rplaced_q;

	always_comb begin
		vtot_nx = vtot_q;
		if (put_wr) vtot_nx = vtot_q + CNT_W'(1);
		else if (del_clr) vtot_nx = vtot_q - CNT_W'(1);
	end

	always_comb begin
		rsp_nx = '0;
		rsp_nx.occupied_count = vtot_nx;
		if (cmd.put_step) begin
			rsp_nx.placed       = put_wr;
			rsp_nx.placed_total = rplaced_nx;
			rsp_nx.position     = put_wr ? cur_q[SLOT_W-1:0] : '0;
			rsp_nx.run_done     = req_q.last;
		end
		if (cmd.find_step) begin
			rsp_nx.found    = find_hit;
			rsp_nx.position = find_hit ? rd_addr_s1 : '0;
		end
	end

	assign res_ld = (cmd.put_step && put_fin) || (cmd.find_step && find_fin) || cmd.other_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vtot_q    <= '0;
			cur_q     <= '0;
			wend_q    <= '0;
			rplaced_q <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			vtot_q <= vtot_nx;
			if (cmd.load) begin
				scan_q    <= '0;
				rd_vld_s1 <= 1'b0;
				if ((req.func == OP_PUT) && req.first) begin
					cur_q     <= {1'b0, req.index};
					wend_q    <= wend_init;
					rplaced_q <= '0;
				end
			end
			if (cmd.put_step) begin
				rplaced_q <= rplaced_nx;
				if (put_wr) begin
					valid_q[cur_q[SLOT_W-1:0]] <= 1'b1;
				end
				// run closes after its last element
				if (put_fin && req_q.last) begin
					cur_q  <= '0;
					wend_q <= '0;
				end else if (put_wr) begin
					cur_q <= cur_q + CNT_W'(1);
				end else if (!put_in_win) begin
					cur_q <= wend_q;
				end else begin
					cur_q <= cur_q + CNT_W'(1);
				end
			end
			if (cmd.find_step) begin
				if (scan_q < CNT_W'(CAPACITY)) begin
					rd_vld_s1 <= 1'b1;
					scan_q    <= scan_q + CNT_W'(1);
				end else begin
					rd_vld_s1 <= 1'b0;
				end
			end
			if (del_clr) begin
				valid_q[req_q.index] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (res_ld) rsp_q <= rsp_nx;
		if (put_wr) mem[cur_q[SLOT_W-1:0]] <= req_q.elem;
		if (cmd.find_step) begin
			rd_data_s1 <= mem[scan_q[SLOT_W-1:0]];
			rd_addr_s1 <= scan_q[SLOT_W-1:0];
		end
	end

	always_comb begin
		sts.put_fin  = put_fin;
		sts.find_fin = find_fin;
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> rtl/slotted_table_with_search_top.sv
// Slot table of 64 entries with put, find and delete. A command is taken when start is high
// and busy is low; its result appears on rsp for exactly one cycle with done high and cannot
// be stalled, so the receiver must take it then. Busy stays high from the command until the
// cycle after the result. A put scans from its cursor past occupied slots until it finds a free
// slot or leaves the window; a find compares slots in order until the first match or until all
// 64 slots are compared. The scan loop visits one slot per cycle through the single read port
// of the value memory or the valid bits. Valid bits clear at reset, so no clearing pass is
// needed.
`default_nettype none

module slotted_table_with_search_top import stws_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output resp_t     rsp
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	stws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (req.func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	stws_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result shown while idle");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer taken but block not busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");

	a_placed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.placed) |-> (rsp.placed_total != '0) && (rsp.occupied_count != '0))
		else $error("placed element not counted");

endmodule

`default_nettype wire
